// ===== rtl/uart_interrupt_transfer_engine_core_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef UART_INTERRUPT_TRANSFER_ENGINE_CORE_DEFINES_SVH
`define UART_INTERRUPT_TRANSFER_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted (active low reset).
`define UITE_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("uite assertion failed");
// Clocked check that also holds during reset.
`define UITE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("uite assertion failed");
`else
`define UITE_ASSERT(name, clk, rstn, prop)
`define UITE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/uite_pkg.sv =====
`timescale 1ns / 1ps
package uite_pkg;

    localparam int CNT_W  = 13;
    localparam int IDX_W  = 12;
    localparam int LEN_W  = 13;
    localparam int EN_W   = 6;
    localparam int FLAG_W = 7;
    localparam int ICR_W  = 6;

    typedef enum logic [2:0] {
        OP_START_TX = 3'd0,
        OP_START_RX = 3'd1,
        OP_EVENT    = 3'd2,
        OP_KILL_TX  = 3'd3,
        OP_KILL_RX  = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PH_READY    = 2'd0,
        PH_ONGOING  = 2'd1,
        PH_COMPLETE = 2'd2,
        PH_ABORTED  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_BAD_LEN = 2'd2
    } ret_code_t;

    // enable bit positions
    localparam int EN_TE     = 0;
    localparam int EN_RE     = 1;
    localparam int EN_TXEIE  = 2;
    localparam int EN_TCIE   = 3;
    localparam int EN_RXNEIE = 4;
    localparam int EN_IDLEIE = 5;

    // event bit positions
    localparam int EV_TXE  = 0;
    localparam int EV_TC   = 1;
    localparam int EV_RXNE = 2;
    localparam int EV_IDLE = 3;
    localparam int EV_ORE  = 4;
    localparam int EV_PE   = 5;
    localparam int EV_NF   = 6;
    localparam int EV_FE   = 7;

    // interrupt clear bit positions
    localparam int ICR_TC   = 0;
    localparam int ICR_IDLE = 1;
    localparam int ICR_ORE  = 2;
    localparam int ICR_NF   = 3;
    localparam int ICR_FE   = 4;
    localparam int ICR_PE   = 5;

    // runtime flag bit positions
    localparam int FL_TX_DONE = 0;
    localparam int FL_RX_DONE = 1;
    localparam int FL_IDLE_AB = 2;
    localparam int FL_ORE     = 3;
    localparam int FL_PE      = 4;
    localparam int FL_NF      = 5;
    localparam int FL_FE      = 6;

endpackage

// ===== rtl/uart_interrupt_transfer_engine_core.sv =====
`timescale 1ns / 1ps
// Interrupt-driven UART transfer sequencer. Each input word is either a
// command (start/kill transmit or receive, clear runtime flags) or one serial
// event snapshot, and each produces exactly one result word that reports the
// transmit-register load or receive-buffer store to perform, the interrupt
// flags to clear, the control enables, both transfer phases, the latched
// runtime flags and an optional wakeup pulse. Throughput is one word per
// clock; the result is registered in a single output register in the cycle
// after the input word is taken. The input side stalls only while that register
// holds a word the downstream side has not taken. The wakeup_attached bit is
// written through the cfg port and should only change while no word is in
// flight.
`include "uart_interrupt_transfer_engine_core_defines.svh"

module uart_interrupt_transfer_engine_core
    import uite_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: cfg_data[0] = wakeup_attached
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // [12:0] length, [20:13] event_flags, [28:21] rx_byte, [35:29] clear_mask
    input  logic [39:0] s_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_tuser,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status_code, [2] tdr_load, [3] rx_store, [15:4] buffer_index,
    // [23:16] rx_data, [29:24] icr_clear, [35:30] control_bits,
    // [37:36] tx_phase, [39:38] rx_phase, [46:40] runtime_flags, [47] wakeup
    output logic [47:0] m_tdata
);

    // length limit, held in 17 bits (MAX_LEN is truncated to that width)
    localparam logic [16:0] LEN_MAX = 17'(MAX_LEN);

    // architectural state
    phase_t              tx_state_reg, tx_state_next;
    logic [CNT_W-1:0]    tx_idx_reg, tx_idx_next;
    logic [CNT_W-1:0]    tx_left_reg, tx_left_next;
    phase_t              rx_state_reg, rx_state_next;
    logic [CNT_W-1:0]    rx_idx_reg, rx_idx_next;
    logic [CNT_W-1:0]    rx_left_reg, rx_left_next;
    logic [EN_W-1:0]     en_reg, en_next;
    logic [FLAG_W-1:0]   flag_reg, flag_next;
    logic                wake_att_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [47:0]         m_data_reg, m_data_next;

    // per-word result fields
    ret_code_t           status_c;
    logic                tdr_c, sto_c, wake_c;
    logic [IDX_W-1:0]    idx_c;
    logic [7:0]          rdat_c;
    logic [ICR_W-1:0]    icr_c;

    // unpacked input word
    op_t                 op_in;
    logic [LEN_W-1:0]    len_in;
    logic [7:0]          ev_in;
    logic [7:0]          rxb_in;
    logic [FLAG_W-1:0]   cmask_in;
    logic                len_bad;
    logic                s_accept;

    assign op_in    = op_t'(s_tuser);
    assign len_in   = s_tdata[12:0];
    assign ev_in    = s_tdata[20:13];
    assign rxb_in   = s_tdata[28:21];
    assign cmask_in = s_tdata[35:29];

    assign len_bad  = (len_in == '0) || ({4'd0, len_in} > LEN_MAX);

    // take a new word whenever the output register is free or draining
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Next state: apply one command or event to the transfer state.
    always_comb begin
        logic [EN_W-1:0] cache;
        logic            txe, tc, rxne, idle, idx_set;

        tx_state_next = tx_state_reg;
        tx_idx_next   = tx_idx_reg;
        tx_left_next  = tx_left_reg;
        rx_state_next = rx_state_reg;
        rx_idx_next   = rx_idx_reg;
        rx_left_next  = rx_left_reg;
        en_next       = en_reg;
        flag_next     = flag_reg;
        status_c      = ST_OK;
        tdr_c         = 1'b0;
        sto_c         = 1'b0;
        wake_c        = 1'b0;
        idx_c         = '0;
        rdat_c        = '0;
        icr_c         = '0;
        idx_set       = 1'b0;
        cache         = en_reg;
        txe           = ev_in[EV_TXE];
        tc            = ev_in[EV_TC];
        rxne          = ev_in[EV_RXNE];
        idle          = ev_in[EV_IDLE];

        unique case (op_in)
            OP_START_TX: begin
                if (len_bad) begin
                    status_c = ST_BAD_LEN;
                end else if (tx_state_reg == PH_ONGOING) begin
                    status_c = ST_BUSY;
                end else begin
                    // byte 0 goes out at once
                    tdr_c              = 1'b1;
                    tx_idx_next        = CNT_W'(1);
                    tx_left_next       = len_in - LEN_W'(1);
                    tx_state_next      = PH_ONGOING;
                    en_next[EN_TE]     = 1'b1;
                    en_next[EN_TXEIE]  = 1'b1;
                end
            end
            OP_START_RX: begin
                if (len_bad) begin
                    status_c = ST_BAD_LEN;
                end else if (rx_state_reg == PH_ONGOING ||
                             rx_state_reg == PH_ABORTED) begin
                    status_c = ST_BUSY;
                end else begin
                    rx_idx_next        = '0;
                    rx_left_next       = len_in;
                    rx_state_next      = PH_ONGOING;
                    en_next[EN_RE]     = 1'b1;
                    en_next[EN_RXNEIE] = 1'b1;
                end
            end
            OP_EVENT: begin
                // transmit handlers, gated by the enables at entry
                if ((txe || tc) && (cache[EN_TXEIE] || cache[EN_TCIE])) begin
                    if (tx_state_next == PH_READY) begin
                        icr_c[ICR_TC]     = 1'b1;
                        en_next[EN_TCIE]  = 1'b0;
                        en_next[EN_TXEIE] = 1'b0;
                    end
                    if (txe && tx_state_next == PH_ONGOING) begin
                        if (tx_left_reg != '0) begin
                            en_next[EN_TCIE] = 1'b0;
                            tdr_c            = 1'b1;
                            idx_c            = tx_idx_reg[IDX_W-1:0];
                            idx_set          = 1'b1;
                            tx_idx_next      = tx_idx_reg + CNT_W'(1);
                            tx_left_next     = tx_left_reg - CNT_W'(1);
                        end else begin
                            // last byte gone: wait for TC
                            en_next[EN_TXEIE] = 1'b0;
                            en_next[EN_TCIE]  = 1'b1;
                            tx_state_next     = PH_COMPLETE;
                        end
                    end
                    if (tc && tx_state_next == PH_COMPLETE) begin
                        icr_c[ICR_TC]         = 1'b1;
                        en_next[EN_TCIE]      = 1'b0;
                        en_next[EN_TXEIE]     = 1'b0;
                        flag_next[FL_TX_DONE] = 1'b1;
                        wake_c                = wake_att_reg;
                    end
                end
                // receive handlers
                if (rxne || idle) begin
                    if (rxne && cache[EN_RXNEIE] && rx_state_next == PH_ONGOING) begin
                        en_next[EN_IDLEIE] = 1'b1;
                        icr_c[ICR_IDLE]    = 1'b1;
                        sto_c              = 1'b1;
                        rdat_c             = rxb_in;
                        if (!idx_set) begin
                            idx_c = rx_idx_reg[IDX_W-1:0];
                        end
                        rx_idx_next  = rx_idx_reg + CNT_W'(1);
                        rx_left_next = rx_left_reg - CNT_W'(1);
                        if (rx_left_next == '0) begin
                            en_next[EN_RE]        = 1'b0;
                            en_next[EN_IDLEIE]    = 1'b0;
                            rx_state_next         = PH_COMPLETE;
                            flag_next[FL_RX_DONE] = 1'b1;
                        end
                    end
                    if (idle && cache[EN_IDLEIE] && rx_state_next == PH_ONGOING) begin
                        // line went idle mid-transfer: abort
                        en_next[EN_RE]        = 1'b0;
                        en_next[EN_IDLEIE]    = 1'b0;
                        icr_c[ICR_IDLE]       = 1'b1;
                        rx_state_next         = PH_ABORTED;
                        flag_next[FL_IDLE_AB] = 1'b1;
                    end
                    if ((rx_state_next == PH_ABORTED || rx_state_next == PH_COMPLETE)
                        && wake_att_reg) begin
                        rx_state_next = PH_COMPLETE;
                        wake_c        = 1'b1;
                    end
                end
                // error flags: clear in the peripheral, latch densely
                if (ev_in[EV_ORE]) begin
                    icr_c[ICR_ORE]    = 1'b1;
                    flag_next[FL_ORE] = 1'b1;
                end
                if (ev_in[EV_PE]) begin
                    icr_c[ICR_PE]    = 1'b1;
                    flag_next[FL_PE] = 1'b1;
                end
                if (ev_in[EV_NF]) begin
                    icr_c[ICR_NF]    = 1'b1;
                    flag_next[FL_NF] = 1'b1;
                end
                if (ev_in[EV_FE]) begin
                    icr_c[ICR_FE]    = 1'b1;
                    flag_next[FL_FE] = 1'b1;
                end
            end
            OP_KILL_TX: begin
                en_next[EN_TCIE]  = 1'b0;
                en_next[EN_TXEIE] = 1'b0;
                tx_state_next     = PH_READY;
                tx_idx_next       = '0;
                tx_left_next      = '0;
            end
            OP_KILL_RX: begin
                en_next[EN_RXNEIE] = 1'b0;
                rx_state_next      = PH_READY;
                rx_idx_next        = '0;
                rx_left_next       = '0;
            end
            OP_CLEAR: begin
                flag_next = flag_reg & ~cmask_in;
            end
            default: begin
                // unused opcodes: no effect, status ok
            end
        endcase
    end

    // Output word: load on accept, drop once taken downstream.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {wake_c, flag_next, rx_state_next, tx_state_next, en_next,
                            icr_c, rdat_c, idx_c, sto_c, tdr_c, status_c};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_state_reg <= PH_READY;
            tx_idx_reg   <= '0;
            tx_left_reg  <= '0;
            rx_state_reg <= PH_READY;
            rx_idx_reg   <= '0;
            rx_left_reg  <= '0;
            en_reg       <= '0;
            flag_reg     <= '0;
            wake_att_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                wake_att_reg <= cfg_data;
            end
            if (s_accept) begin
                tx_state_reg <= tx_state_next;
                tx_idx_reg   <= tx_idx_next;
                tx_left_reg  <= tx_left_next;
                rx_state_reg <= rx_state_next;
                rx_idx_reg   <= rx_idx_next;
                rx_left_reg  <= rx_left_next;
                en_reg       <= en_next;
                flag_reg     <= flag_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // wakeup is only raised with a wakeup attached
    `UITE_ASSERT(a_wake_att, aclk, aresetn, (s_accept && wake_c) |-> wake_att_reg)
    // an ongoing transfer keeps its direction enabled
    `UITE_ASSERT(a_tx_te, aclk, aresetn, (tx_state_reg == PH_ONGOING) |-> en_reg[EN_TE])
    `UITE_ASSERT(a_rx_re, aclk, aresetn, (rx_state_reg == PH_ONGOING) |-> en_reg[EN_RE])
    // every accepted word shows up in the output register
    `UITE_ASSERT(a_accept_out, aclk, aresetn, s_accept |=> m_valid_reg)

endmodule
